/* sv/vbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared types and codes for the variable-length bit packer.
// ----------------------------------------------------------------------------
package vbp_pkg;

	localparam int STORE_BITS  = 64;
	localparam int WORD_BITS   = 32;
	localparam int QUEUE_DEPTH = 4;

	// input commands
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_PEEK   = 2'd1;
	localparam logic [1:0] CMD_UNLOAD = 2'd2;
	localparam logic [1:0] CMD_CLOSE  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_WORD  = 2'd0;
	localparam logic [1:0] KIND_PEEK  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic MODE_PACK = 1'b0;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_PEEK,
		OP_UNLOAD,
		OP_CLOSE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] code_value;
		logic [5:0]  bit_length;
		logic [31:0] refill_word;
		logic        refill_valid;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] data_word;
		logic        took_refill;
		logic        last_result;
	} out_item_t;

	// classified operation handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] code_lj;      // code left-justified in a word, masked
		logic [5:0]  len;          // saturated for writes, raw for unloads
		logic [31:0] refill_word;
		logic        refill_valid;
	} op_item_t;

	typedef struct packed {
		logic     valid;
		op_item_t item;
	} op_chan_t;

endpackage

/* sv/vbp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbp_front
// Holds the mode register and turns accepted commands into operations.
// ----------------------------------------------------------------------------
module vbp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              queue_full,
	input  vbp_pkg::in_item_t item,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	output logic              cfg_ready,
	output logic              cfg_clear,
	output vbp_pkg::op_chan_t op_out
);
	import vbp_pkg::*;

	logic        mode_q;
	logic        accept;
	logic [5:0]  sat_len;
	logic [31:0] code_lj;
	op_t         op;

	assign cfg_ready = 1'b1;
	assign cfg_clear = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PACK;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign accept  = push && !queue_full;
	assign sat_len = (item.bit_length > 6'd32) ? 6'd32 : item.bit_length;
	// shifting out the top bits also masks the code to its length
	assign code_lj = item.code_value << (6'd32 - sat_len);

	always_comb begin
		op = OP_NONE;
		case (item.cmd)
			CMD_WRITE: begin
				if (mode_q == MODE_PACK && sat_len != 6'd0) op = OP_WRITE;
			end
			CMD_PEEK: begin
				if (mode_q != MODE_PACK) op = OP_PEEK;
			end
			CMD_UNLOAD: begin
				if (mode_q != MODE_PACK) op = OP_UNLOAD;
			end
			CMD_CLOSE: begin
				op = (mode_q == MODE_PACK) ? OP_CLOSE : OP_CLEAR;
			end
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		op_out.valid             = accept && (op != OP_NONE);
		op_out.item.op           = op;
		op_out.item.code_lj      = code_lj;
		op_out.item.len          = (op == OP_WRITE) ? sat_len : item.bit_length;
		op_out.item.refill_word  = item.refill_word;
		op_out.item.refill_valid = item.refill_valid;
	end

endmodule

/* sv/vbp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbp_fifo
// Short operation queue between the front and the back.
// ----------------------------------------------------------------------------
module vbp_fifo #(
	parameter int DEPTH = vbp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vbp_pkg::op_chan_t  wr,
	input  logic               rd,
	output logic               full,
	output logic               head_valid,
	output vbp_pkg::op_item_t  head
);
	import vbp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_item_t        mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_ptr_q];
	assign do_wr      = wr.valid && !full;
	assign do_rd      = rd && head_valid;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) mem[wr_ptr_q] <= wr.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* sv/vbp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbp_back
// Executes queued operations on the bit store and drives the result register.
// ----------------------------------------------------------------------------
module vbp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_clear,
	input  logic               head_valid,
	input  vbp_pkg::op_item_t  head,
	output logic               head_pop,
	input  logic               pop,
	output logic               empty,
	output vbp_pkg::out_item_t result
);
	import vbp_pkg::*;

	logic [STORE_BITS-1:0] store_q;
	logic [6:0]            count_q;
	logic [1:0]            idx_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [STORE_BITS-1:0] store_n;
	logic [6:0]            count_n;
	logic [1:0]            nres;
	out_item_t             res;
	logic                  emit;
	logic [STORE_BITS-1:0] s_tmp;
	logic [6:0]            c_tmp;
	logic                  low;
	logic [5:0]            sh;
	logic [31:0]           win;
	logic                  has_out;
	logic                  last;
	logic                  slot_free;
	logic                  go;
	logic                  done;

	always_comb begin
		store_n = store_q;
		count_n = count_q;
		nres    = 2'd0;
		res     = '0;
		emit    = 1'b0;
		s_tmp   = store_q;
		c_tmp   = count_q;
		low     = 1'b0;
		sh      = '0;
		win     = '0;
		case (head.op)
			OP_WRITE: begin
				emit  = (7'd64 - count_q) < {1'b0, head.len};
				s_tmp = emit ? {store_q[31:0], 32'b0} : store_q;
				c_tmp = emit ? count_q - 7'd32 : count_q;
				store_n = s_tmp | ({head.code_lj, 32'b0} >> c_tmp[5:0]);
				count_n = c_tmp + {1'b0, head.len};
				nres    = emit ? 2'd1 : 2'd0;
				res.result_kind = KIND_WORD;
				res.data_word   = store_q[63:32];
			end
			OP_PEEK: begin
				low  = count_q < 7'd32;
				nres = 2'd1;
				if (low && !head.refill_valid) begin
					res.result_kind = KIND_ERROR;
				end else begin
					s_tmp   = low ? {store_q[31:0], head.refill_word} : store_q;
					c_tmp   = low ? count_q + 7'd32 : count_q;
					sh      = 6'(c_tmp - 7'd32);
					win     = 32'(s_tmp >> sh);
					store_n = s_tmp;
					count_n = c_tmp;
					res.result_kind = KIND_PEEK;
					res.data_word   = win;
					res.took_refill = low;
				end
			end
			OP_UNLOAD: begin
				count_n = ({1'b0, head.len} >= count_q) ? 7'd0
				                                         : count_q - {1'b0, head.len};
			end
			OP_CLOSE: begin
				// padding 32 zeros spills the upper word first when more than 32 held
				if (count_q == 7'd0)       nres = 2'd1;
				else if (count_q > 7'd32)  nres = 2'd3;
				else                       nres = 2'd2;
				res.result_kind = KIND_WORD;
				case (idx_q)
					2'd0:    res.data_word = store_q[63:32];
					2'd1:    res.data_word = store_q[31:0];
					default: res.data_word = 32'b0;
				endcase
				store_n = '0;
				count_n = '0;
			end
			OP_CLEAR: begin
				store_n = '0;
				count_n = '0;
			end
			default: ;
		endcase
		has_out         = (nres != 2'd0);
		last            = (idx_q == nres - 2'd1);
		res.last_result = last;
	end

	assign slot_free = !out_valid_q || pop;
	assign go        = head_valid && (!has_out || slot_free);
	assign done      = go && (!has_out || last);
	assign head_pop  = done;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_clear) begin
				store_q <= '0;
				count_q <= '0;
			end else if (done) begin
				store_q <= store_n;
				count_q <= count_n;
			end
			if (done)                    idx_q <= '0;
			else if (go && has_out)      idx_q <= idx_q + 2'd1;
			if (go && has_out)           out_valid_q <= 1'b1;
			else if (pop)                out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_out) out_q <= res;
	end

endmodule

/* sv/variable_length_bit_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_bit_packer_core
// Packs variable-length codes into 32-bit words, or peeks/unloads bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive item and raise push; the transaction
//   happens on a clock edge with push high and full low.
//   Result side is a queue: while empty is low, result holds the oldest
//   result; it is taken on an edge with pop high.
//   cfg_data selects pack (0) or unpack (1); a cfg transaction also clears
//   the bit store. cfg_ready is always high. Write it only while idle.
// Timing:
//   A result passes through the op queue and then the result register before
//   it is on the ports. Items are taken one per cycle while full is low;
//   a close with bits held emits two or three words, one per cycle while
//   the result register is free; items with no result leave that register alone.
// Reset clears mode, store, queue and result register. When the receiver
// stalls, the result register holds, the back end halts at an operation with
// a result and the op queue fills; full rises once QUEUE_DEPTH ops wait.
// ----------------------------------------------------------------------------
module variable_length_bit_packer_core #(
	parameter int QUEUE_DEPTH = vbp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  vbp_pkg::in_item_t  item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output logic               empty,
	input  logic               pop,
	output vbp_pkg::out_item_t result
);
	import vbp_pkg::*;

	op_chan_t op_ch;
	op_item_t head;
	logic     head_valid;
	logic     head_pop;
	logic     cfg_clear;

	vbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.queue_full (full),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cfg_ready  (cfg_ready),
		.cfg_clear  (cfg_clear),
		.op_out     (op_ch)
	);

	vbp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (op_ch),
		.rd         (head_pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	vbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_clear  (cfg_clear),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
